FILE: rtl/core/ttyild_pkg.sv
// shared types, constants and helpers for the tty input line discipline
package ttyild_pkg;

    localparam int BUF_DEPTH_DEF = 256;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int ECHO_MAX   = 6;

    // mode register codes, the unused code behaves as cooked
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_CBREAK = 2'd1;
    localparam logic [1:0] MODE_COOKED = 2'd2;

    // option flag bit positions
    localparam int OPT_CRLF_MAP  = 0;
    localparam int OPT_FLOW      = 1;
    localparam int OPT_ECHO      = 2;
    localparam int OPT_KILL      = 3;
    localparam int OPT_ERASE     = 4;
    localparam int OPT_ECHO_CRLF = 5;
    localparam int OPT_VISUAL    = 6;
    localparam int OPT_BS_SP_BS  = 7;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_UP  = 8'd94;
    localparam logic [7:0] CH_DEL = 8'o177;
    localparam logic [7:0] VIS_OFFSET = 8'o100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_MODE   = 3'd0,
        CFG_OPTION_FLAGS = 3'd1,
        CFG_START_CHAR   = 3'd2,
        CFG_STOP_CHAR    = 3'd3,
        CFG_KILL_CHAR    = 3'd4,
        CFG_ERASE_CHAR   = 3'd5,
        CFG_FULL_CHAR    = 3'd6
    } t_cfg_idx;

    localparam logic [7:0] START_DEF = 8'd17;
    localparam logic [7:0] STOP_DEF  = 8'd19;
    localparam logic [7:0] KILL_DEF  = 8'd21;
    localparam logic [7:0] ERASE_DEF = 8'd8;
    localparam logic [7:0] FULL_DEF  = 8'd7;

    // what echo the emitter has to produce for one character
    typedef enum logic [2:0] {
        EK_NONE,
        EK_FULL,
        EK_CHAR,
        EK_CRLF,
        EK_ERASE
    } t_echo_kind;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c < CH_SP) || (c == CH_DEL);
    endfunction

endpackage

FILE: rtl/core/tty_input_line_discipline_unit.sv
// tty input line discipline: raw, cbreak and cooked input with echo generation
//
//  channel   | dir | handshake               | contents
//  ----------+-----+-------------------------+----------------------------------------
//  s_axis    | in  | tvalid/tready           | one received character per transaction
//  m_axis    | out | tvalid/tready, tlast    | one echo/store result per transaction
//  cfg       | in  | valid/ready (always 1)  | register index and write data
//
//  an accepted character is decided in its accept cycle: the buffer ram is written or
//  read there, a decode register holds it for the ram read data, then the result
//  register emits 1 to 6 results, one per cycle while m_axis tready is high, the count
//  set by the echo. a new character is taken while results of the previous ones are
//  still being delivered. synchronous active-low reset clears pointers, hold flag and
//  valid flags and loads the configuration defaults; the buffer ram is not cleared.
//  a stall on m_axis backs up into s_axis tready.
module tty_input_line_discipline_unit #(
    parameter int BUF_DEPTH = ttyild_pkg::BUF_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] rx_char, [17:8] pending_count, [23:18] zero
    input  logic [ttyild_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [0] rx_error
    input  logic [0:0]                            i_s_axis_tuser,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [9] store_valid, [17:10] store_index,
    // [25:18] store_char, [26] store_error, [35:27] release_count,
    // [36] output_held, [39:37] zero
    output logic [ttyild_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ttyild_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                            i_cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int SW = $clog2(BUF_DEPTH + 512) + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

    // configuration registers
    logic [1:0] r_mode;
    logic [7:0] r_opt;
    logic [7:0] r_start_ch;
    logic [7:0] r_stop_ch;
    logic [7:0] r_kill_ch;
    logic [7:0] r_erase_ch;
    logic [7:0] r_full_ch;

    // line state
    logic [AW-1:0] r_wh;
    logic [AW-1:0] r_cur;
    logic          r_hold;
    logic [AW-1:0] n_wh;
    logic [AW-1:0] n_cur;
    logic          n_hold;

    // decode register
    logic                   r_s1_valid;
    ttyild_pkg::t_echo_kind r_s1_kind;
    logic [7:0]             r_s1_ech;
    logic                   r_s1_st_v;
    logic [7:0]             r_s1_st_idx;
    logic [7:0]             r_s1_st_ch;
    logic                   r_s1_st_err;
    logic [8:0]             r_s1_rel;
    logic                   r_s1_hold;

    // result register
    logic                   r_em_valid;
    logic [7:0]             r_em_echo [ttyild_pkg::ECHO_MAX];
    logic [2:0]             r_em_n;
    logic [2:0]             r_em_last_k;
    logic [2:0]             r_em_k;
    logic                   r_em_st_v;
    logic [7:0]             r_em_st_idx;
    logic [7:0]             r_em_st_ch;
    logic                   r_em_st_err;
    logic [8:0]             r_em_rel;
    logic                   r_em_hold;

    // accept-side decode
    logic                   acc;
    logic [7:0]             in_ch;
    logic [7:0]             ch_eff;
    logic signed [9:0]      pend;
    logic signed [SW-1:0]   pend_x;
    logic [SW-1:0]          ct;
    logic                   full_raw;
    logic                   line_full;
    logic [AW-1:0]          wh_inc;
    logic [AW-1:0]          wh_dec;
    logic [AW-1:0]          wh_kill;
    ttyild_pkg::t_echo_kind s_kind;
    logic [7:0]             s_ech;
    logic                   s_st_v;
    logic [8:0]             s_rel;
    logic                   rd_need;
    logic [8:0]             ram_rdata;

    // emitter load
    logic                   em_done;
    logic                   em_free;
    logic                   em_load;
    logic [7:0]             b_echo [ttyild_pkg::ECHO_MAX];
    logic [2:0]             b_n;
    logic                   mem_ctl;
    logic                   em_fin;
    logic                   em_echo_v;

    assign in_ch = i_s_axis_tdata[7:0];
    assign pend  = $signed(i_s_axis_tdata[17:8]);

    assign em_done = r_em_valid && i_m_axis_tready && (r_em_k == r_em_last_k);
    assign em_free = !r_em_valid || em_done;
    assign em_load = r_s1_valid && em_free;
    assign o_s_axis_tready = !r_s1_valid || em_free;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cfg_ready = 1'b1;

    // ring pointer arithmetic, depth need not be a power of two
    always_comb begin
        logic [AW:0] wrap;
        wh_inc  = (r_wh == LAST_IDX) ? '0 : r_wh + AW'(1);
        wh_dec  = (r_wh == '0) ? LAST_IDX : r_wh - AW'(1);
        wrap    = {1'b0, r_wh} + (AW+1)'(BUF_DEPTH) - {1'b0, r_cur};
        wh_kill = (r_wh >= r_cur) ? (r_wh - r_cur) : wrap[AW-1:0];
    end

    always_comb begin
        pend_x    = SW'(pend);
        ct        = pend_x[SW-1] ? '0 : SW'(pend_x);
        full_raw  = pend_x >= $signed(SW'(BUF_DEPTH));
        line_full = (ct + SW'(r_cur)) >= SW'(BUF_DEPTH - 1);
    end

    always_comb begin
        ch_eff = in_ch;
        if (r_mode != ttyild_pkg::MODE_RAW && in_ch == ttyild_pkg::CH_CR &&
            r_opt[ttyild_pkg::OPT_CRLF_MAP]) begin
            ch_eff = ttyild_pkg::CH_LF;
        end
    end

    always_comb begin
        n_wh    = r_wh;
        n_cur   = r_cur;
        n_hold  = r_hold;
        s_kind  = ttyild_pkg::EK_NONE;
        s_ech   = ch_eff;
        s_st_v  = 1'b0;
        s_rel   = '0;
        rd_need = 1'b0;
        if (r_mode == ttyild_pkg::MODE_RAW) begin
            if (!full_raw) begin
                s_st_v = 1'b1;
                s_rel  = 9'd1;
            end
        end else if (r_opt[ttyild_pkg::OPT_FLOW] && ch_eff == r_start_ch) begin
            n_hold = 1'b0;
        end else if (r_opt[ttyild_pkg::OPT_FLOW] && ch_eff == r_stop_ch) begin
            n_hold = 1'b1;
        end else begin
            n_hold = 1'b0;
            if (r_mode == ttyild_pkg::MODE_CBREAK) begin
                if (full_raw) begin
                    s_kind = ttyild_pkg::EK_FULL;
                    s_ech  = r_full_ch;
                end else begin
                    s_st_v = 1'b1;
                    s_rel  = 9'd1;
                    if (r_opt[ttyild_pkg::OPT_ECHO]) begin
                        s_kind = ttyild_pkg::EK_CHAR;
                    end
                end
            end else if (ch_eff == r_kill_ch && r_opt[ttyild_pkg::OPT_KILL]) begin
                n_wh   = wh_kill;
                n_cur  = '0;
                s_kind = ttyild_pkg::EK_CRLF;
            end else if (ch_eff == r_erase_ch && r_opt[ttyild_pkg::OPT_ERASE]) begin
                if (r_cur != '0) begin
                    n_cur   = r_cur - AW'(1);
                    n_wh    = wh_dec;
                    rd_need = 1'b1;
                    if (r_opt[ttyild_pkg::OPT_ECHO]) begin
                        s_kind = ttyild_pkg::EK_ERASE;
                    end
                end
            end else if (ch_eff == ttyild_pkg::CH_LF || ch_eff == ttyild_pkg::CH_CR) begin
                if (r_opt[ttyild_pkg::OPT_ECHO]) begin
                    s_kind = ttyild_pkg::EK_CHAR;
                end
                s_st_v = 1'b1;
                s_rel  = 9'({1'b0, r_cur} + (AW+1)'(1));
                n_cur  = '0;
            end else if (line_full) begin
                s_kind = ttyild_pkg::EK_FULL;
                s_ech  = r_full_ch;
            end else begin
                if (r_opt[ttyild_pkg::OPT_ECHO]) begin
                    s_kind = ttyild_pkg::EK_CHAR;
                end
                n_cur  = r_cur + AW'(1);
                s_st_v = 1'b1;
            end
        end
        // a store never coincides with kill or erase
        if (s_st_v) begin
            n_wh = wh_inc;
        end
    end

    // erase reads the entry it steps back over, after the previous write has landed
    ttyild_ram #(
        .WIDTH (9),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (acc && s_st_v),
        .i_waddr (r_wh),
        .i_wdata ({i_s_axis_tuser[0], ch_eff}),
        .i_re    (acc && rd_need),
        .i_raddr (wh_dec),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ttyild_pkg::MODE_COOKED;
            r_opt      <= '0;
            r_start_ch <= ttyild_pkg::START_DEF;
            r_stop_ch  <= ttyild_pkg::STOP_DEF;
            r_kill_ch  <= ttyild_pkg::KILL_DEF;
            r_erase_ch <= ttyild_pkg::ERASE_DEF;
            r_full_ch  <= ttyild_pkg::FULL_DEF;
        end else if (i_cfg_valid) begin
            unique case (ttyild_pkg::t_cfg_idx'(i_cfg_index))
                ttyild_pkg::CFG_INPUT_MODE:   r_mode     <= i_cfg_data[1:0];
                ttyild_pkg::CFG_OPTION_FLAGS: r_opt      <= i_cfg_data;
                ttyild_pkg::CFG_START_CHAR:   r_start_ch <= i_cfg_data;
                ttyild_pkg::CFG_STOP_CHAR:    r_stop_ch  <= i_cfg_data;
                ttyild_pkg::CFG_KILL_CHAR:    r_kill_ch  <= i_cfg_data;
                ttyild_pkg::CFG_ERASE_CHAR:   r_erase_ch <= i_cfg_data;
                ttyild_pkg::CFG_FULL_CHAR:    r_full_ch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh       <= '0;
            r_cur      <= '0;
            r_hold     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_wh   <= n_wh;
                r_cur  <= n_cur;
                r_hold <= n_hold;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (em_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind   <= s_kind;
            r_s1_ech    <= s_ech;
            r_s1_st_v   <= s_st_v;
            r_s1_st_idx <= 8'(r_wh);
            r_s1_st_ch  <= ch_eff;
            r_s1_st_err <= i_s_axis_tuser[0];
            r_s1_rel    <= s_rel;
            r_s1_hold   <= n_hold;
        end
    end

    assign mem_ctl = ttyild_pkg::is_ctl(ram_rdata[7:0]);

    // expand the echo of one character into up to six result characters
    always_comb begin
        for (int i = 0; i < ttyild_pkg::ECHO_MAX; i++) begin
            b_echo[i] = ttyild_pkg::CH_BS;
        end
        b_n = 3'd0;
        unique case (r_s1_kind)
            ttyild_pkg::EK_NONE: ;
            ttyild_pkg::EK_FULL: begin
                b_echo[0] = r_s1_ech;
                b_n       = 3'd1;
            end
            ttyild_pkg::EK_CRLF: begin
                b_echo[0] = ttyild_pkg::CH_CR;
                b_echo[1] = ttyild_pkg::CH_LF;
                b_n       = 3'd2;
            end
            ttyild_pkg::EK_CHAR: begin
                if ((r_s1_ech == ttyild_pkg::CH_LF || r_s1_ech == ttyild_pkg::CH_CR) &&
                    r_opt[ttyild_pkg::OPT_ECHO_CRLF]) begin
                    b_echo[0] = ttyild_pkg::CH_CR;
                    b_echo[1] = ttyild_pkg::CH_LF;
                    b_n       = 3'd2;
                end else if (ttyild_pkg::is_ctl(r_s1_ech) && r_opt[ttyild_pkg::OPT_VISUAL]) begin
                    b_echo[0] = ttyild_pkg::CH_UP;
                    b_echo[1] = r_s1_ech + ttyild_pkg::VIS_OFFSET;
                    b_n       = 3'd2;
                end else begin
                    b_echo[0] = r_s1_ech;
                    b_n       = 3'd1;
                end
            end
            ttyild_pkg::EK_ERASE: begin
                // a visually echoed control char takes two backspaces
                if (r_opt[ttyild_pkg::OPT_BS_SP_BS]) begin
                    b_echo[1] = ttyild_pkg::CH_SP;
                    b_echo[4] = ttyild_pkg::CH_SP;
                    b_n = (mem_ctl && r_opt[ttyild_pkg::OPT_VISUAL]) ? 3'd6 : 3'd3;
                end else begin
                    b_n = (mem_ctl && r_opt[ttyild_pkg::OPT_VISUAL]) ? 3'd2 : 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
            r_em_k     <= '0;
        end else if (em_load) begin
            r_em_valid <= 1'b1;
            r_em_k     <= '0;
        end else if (em_done) begin
            r_em_valid <= 1'b0;
        end else if (r_em_valid && i_m_axis_tready) begin
            r_em_k <= r_em_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_load) begin
            r_em_echo   <= b_echo;
            r_em_n      <= b_n;
            r_em_last_k <= (b_n == 3'd0) ? 3'd0 : b_n - 3'd1;
            r_em_st_v   <= r_s1_st_v;
            r_em_st_idx <= r_s1_st_idx;
            r_em_st_ch  <= r_s1_st_ch;
            r_em_st_err <= r_s1_st_err;
            r_em_rel    <= r_s1_rel;
            r_em_hold   <= r_s1_hold;
        end
    end

    assign em_fin    = (r_em_k == r_em_last_k);
    assign em_echo_v = (r_em_k < r_em_n);

    assign o_m_axis_tvalid = r_em_valid;
    assign o_m_axis_tlast  = em_fin;
    assign o_m_axis_tdata  = {
        3'b000,
        r_em_hold,
        em_fin ? r_em_rel : 9'd0,
        em_fin & r_em_st_v & r_em_st_err,
        (em_fin && r_em_st_v) ? r_em_st_ch : 8'd0,
        (em_fin && r_em_st_v) ? r_em_st_idx : 8'd0,
        em_fin & r_em_st_v,
        em_echo_v ? r_em_echo[r_em_k] : 8'd0,
        em_echo_v
    };

endmodule

FILE: rtl/core/ttyild_ram.sv
// generic single write port ram with registered read
module ttyild_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = ttyild_pkg::BUF_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/tty_input_line_discipline_unit_tb.sv
// self-checking testbench for the tty input line discipline with a built-in predictor
module tty_input_line_discipline_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttyild_pkg::*;

    localparam int          LINE_DEPTH        = BUF_DEPTH_DEF;
    localparam int          RES_MAX           = ECHO_MAX;
    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int          TAIL_CYCLES       = 12;
    localparam int          PHASE_ITEMS       = 8;
    localparam int          LONG_LINE_CHARS   = 258;
    // the spare mode code, decoded like cooked
    localparam logic [1:0]  MODE_COOKED_ALT   = 2'd3;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] flags;
        logic [7:0] start_ch;
        logic [7:0] stop_ch;
        logic [7:0] kill_ch;
        logic [7:0] erase_ch;
        logic [7:0] full_ch;
    } t_line_cfg;

    typedef struct {
        logic [7:0]        rx_char;
        logic              rx_error;
        logic signed [9:0] pending;
        logic              drain_first;
    } t_rx_item;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_char;
        logic       store_error;
        logic [8:0] release_count;
        logic       held;
        logic       last;
    } t_echo_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [0:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [7:0]            i_cfg_data = '0;

    tty_input_line_discipline_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers and the line state
    t_line_cfg    active_cfg = '{MODE_COOKED, 8'h00, START_DEF, STOP_DEF,
                                 KILL_DEF, ERASE_DEF, FULL_DEF};
    logic [8:0]   line_buf [LINE_DEPTH];
    logic [7:0]   buf_head = '0;
    logic [8:0]   edit_cursor = '0;
    logic         out_held = 1'b0;
    logic [7:0]   echo_seq [$];

    t_rx_item     rx_queue [$];
    t_echo_result results_due [$];
    int           mismatches = 0;
    int unsigned  cycle_count = 0;

    function automatic logic ctl_char(logic [7:0] c);
        return (c < CH_SP) || (c == CH_DEL);
    endfunction

    function automatic void echo_visible(logic [7:0] c);
        if ((c == CH_LF || c == CH_CR) && active_cfg.flags[OPT_ECHO_CRLF]) begin
            echo_seq.push_back(CH_CR);
            echo_seq.push_back(CH_LF);
        end else if (ctl_char(c) && active_cfg.flags[OPT_VISUAL]) begin
            echo_seq.push_back(CH_UP);
            echo_seq.push_back(c + VIS_OFFSET);
        end else begin
            echo_seq.push_back(c);
        end
    endfunction

    function automatic void rub_out();
        echo_seq.push_back(CH_BS);
        if (active_cfg.flags[OPT_BS_SP_BS]) begin
            echo_seq.push_back(CH_SP);
            echo_seq.push_back(CH_BS);
        end
    endfunction

    // works out the results of one accepted character and queues them
    function automatic void predict_line_discipline(t_rx_item it);
        logic [7:0]   ch;
        int           pend;
        int           room;
        int           nres;
        logic         stored;
        logic         fin;
        logic [7:0]   store_at;
        logic [8:0]   rel;
        t_echo_result r;
        ch = it.rx_char;
        pend = int'(it.pending);
        stored = 1'b0;
        store_at = '0;
        rel = '0;
        echo_seq.delete();
        if (active_cfg.mode == MODE_RAW) begin
            if (pend < LINE_DEPTH) begin
                stored = 1'b1;
                rel = 9'd1;
            end
        end else begin
            if (ch == CH_CR && active_cfg.flags[OPT_CRLF_MAP])
                ch = CH_LF;
            if (active_cfg.flags[OPT_FLOW] && ch == active_cfg.start_ch) begin
                out_held = 1'b0;
            end else if (active_cfg.flags[OPT_FLOW] && ch == active_cfg.stop_ch) begin
                out_held = 1'b1;
            end else begin
                out_held = 1'b0;
                if (active_cfg.mode == MODE_CBREAK) begin
                    if (pend >= LINE_DEPTH) begin
                        echo_seq.push_back(active_cfg.full_ch);
                    end else begin
                        stored = 1'b1;
                        if (active_cfg.flags[OPT_ECHO])
                            echo_visible(ch);
                        rel = 9'd1;
                    end
                end else if (ch == active_cfg.kill_ch && active_cfg.flags[OPT_KILL]) begin
                    buf_head = buf_head - edit_cursor[7:0];
                    edit_cursor = '0;
                    echo_seq.push_back(CH_CR);
                    echo_seq.push_back(CH_LF);
                end else if (ch == active_cfg.erase_ch && active_cfg.flags[OPT_ERASE]) begin
                    if (edit_cursor != 0) begin
                        edit_cursor = edit_cursor - 9'd1;
                        buf_head = buf_head - 8'd1;
                        if (active_cfg.flags[OPT_ECHO]) begin
                            // a control char was echoed as two glyphs
                            if (ctl_char(line_buf[buf_head][7:0]) &&
                                active_cfg.flags[OPT_VISUAL])
                                rub_out();
                            rub_out();
                        end
                    end
                end else if (ch == CH_LF || ch == CH_CR) begin
                    if (active_cfg.flags[OPT_ECHO])
                        echo_visible(ch);
                    stored = 1'b1;
                    rel = edit_cursor + 9'd1;
                    edit_cursor = '0;
                end else begin
                    room = (pend < 0 ? 0 : pend) + int'(edit_cursor);
                    if (room >= LINE_DEPTH - 1) begin
                        echo_seq.push_back(active_cfg.full_ch);
                    end else begin
                        if (active_cfg.flags[OPT_ECHO])
                            echo_visible(ch);
                        edit_cursor = edit_cursor + 9'd1;
                        stored = 1'b1;
                    end
                end
            end
        end
        if (stored) begin
            store_at = buf_head;
            line_buf[buf_head] = {it.rx_error, ch};
            buf_head = buf_head + 8'd1;
        end
        nres = (echo_seq.size() == 0) ? 1 : echo_seq.size();
        if (nres > RES_MAX)
            nres = RES_MAX;
        for (int k = 0; k < nres; k++) begin
            fin = (k == nres - 1);
            r.echo_valid    = (k < echo_seq.size());
            r.echo_char     = (k < echo_seq.size()) ? echo_seq[k] : 8'd0;
            r.store_valid   = fin && stored;
            r.store_index   = (fin && stored) ? store_at : 8'd0;
            r.store_char    = (fin && stored) ? ch : 8'd0;
            r.store_error   = (fin && stored) ? it.rx_error : 1'b0;
            r.release_count = fin ? rel : 9'd0;
            r.held          = out_held;
            r.last          = fin;
            results_due.push_back(r);
        end
    endfunction

    // sender: bursts of transactions with random gaps in between
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
            if (i_s_axis_tvalid) begin
                predict_line_discipline(rx_queue.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (rx_queue.size() != 0 &&
                         !(rx_queue[0].drain_first && results_due.size() != 0)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {6'b0, rx_queue[0].pending, rx_queue[0].rx_char};
                i_s_axis_tuser  <= rx_queue[0].rx_error;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_field(string field, int unsigned want, int unsigned got);
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // receiver: stall pattern switches between a few shapes
    int ready_mode = 0;
    int ready_span = 0;
    int ready_tick = 0;

    always @(posedge i_clk) begin
        t_echo_result seen;
        t_echo_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.echo_valid    = o_m_axis_tdata[0];
                seen.echo_char     = o_m_axis_tdata[8:1];
                seen.store_valid   = o_m_axis_tdata[9];
                seen.store_index   = o_m_axis_tdata[17:10];
                seen.store_char    = o_m_axis_tdata[25:18];
                seen.store_error   = o_m_axis_tdata[26];
                seen.release_count = o_m_axis_tdata[35:27];
                seen.held          = o_m_axis_tdata[36];
                seen.last          = o_m_axis_tlast;
                if (results_due.size() == 0) begin
                    $display("%0t: result expected none got tdata %h tlast %b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (seen.echo_valid !== want.echo_valid)
                        report_field("echo_valid", want.echo_valid, seen.echo_valid);
                    if (seen.echo_char !== want.echo_char)
                        report_field("echo_char", want.echo_char, seen.echo_char);
                    if (seen.store_valid !== want.store_valid)
                        report_field("store_valid", want.store_valid, seen.store_valid);
                    if (seen.store_index !== want.store_index)
                        report_field("store_index", want.store_index, seen.store_index);
                    if (seen.store_char !== want.store_char)
                        report_field("store_char", want.store_char, seen.store_char);
                    if (seen.store_error !== want.store_error)
                        report_field("store_error", want.store_error, seen.store_error);
                    if (seen.release_count !== want.release_count)
                        report_field("release_count", want.release_count,
                                     seen.release_count);
                    if (seen.held !== want.held)
                        report_field("output_held", want.held, seen.held);
                    if (seen.last !== want.last)
                        report_field("tlast", want.last, seen.last);
                end
            end
            if (ready_span == 0) begin
                ready_mode = $urandom_range(0, 3);
                ready_span = $urandom_range(20, 80);
            end
            ready_span--;
            ready_tick++;
            case (ready_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                2: i_m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: i_m_axis_tready <= (ready_tick % 5 < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[tty_input_line_discipline_unit] ERROR");
            $finish;
        end
    end

    function automatic t_line_cfg make_cfg(logic [1:0] mode, logic [7:0] flags,
                                           logic [7:0] start_ch, logic [7:0] stop_ch,
                                           logic [7:0] kill_ch, logic [7:0] erase_ch,
                                           logic [7:0] full_ch);
        t_line_cfg c;
        c.mode = mode;
        c.flags = flags;
        c.start_ch = start_ch;
        c.stop_ch = stop_ch;
        c.kill_ch = kill_ch;
        c.erase_ch = erase_ch;
        c.full_ch = full_ch;
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_INPUT_MODE:   active_cfg.mode = val[1:0];
            CFG_OPTION_FLAGS: active_cfg.flags = val;
            CFG_START_CHAR:   active_cfg.start_ch = val;
            CFG_STOP_CHAR:    active_cfg.stop_ch = val;
            CFG_KILL_CHAR:    active_cfg.kill_ch = val;
            CFG_ERASE_CHAR:   active_cfg.erase_ch = val;
            CFG_FULL_CHAR:    active_cfg.full_ch = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(t_line_cfg c);
        write_reg(CFG_INPUT_MODE, {6'b0, c.mode});
        write_reg(CFG_OPTION_FLAGS, c.flags);
        write_reg(CFG_START_CHAR, c.start_ch);
        write_reg(CFG_STOP_CHAR, c.stop_ch);
        write_reg(CFG_KILL_CHAR, c.kill_ch);
        write_reg(CFG_ERASE_CHAR, c.erase_ch);
        write_reg(CFG_FULL_CHAR, c.full_ch);
    endtask

    task automatic queue_char(logic [7:0] ch, logic err, int pend, logic drain = 1'b0);
        t_rx_item it;
        it.rx_char = ch;
        it.rx_error = err;
        it.pending = pend[9:0];
        it.drain_first = drain;
        rx_queue.push_back(it);
    endtask

    // block is idle once every queued character has produced all its results
    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_queue.size() != 0 || i_s_axis_tvalid || results_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic int rand_pend();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 6);
            6: return -int'($urandom_range(1, 256));
            7: return $urandom_range(240, 256);
            default: return int'($urandom_range(0, 512)) - 256;
        endcase
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
            5: return active_cfg.erase_ch;
            6: return active_cfg.kill_ch;
            7: return $urandom_range(0, 1) ? active_cfg.start_ch : active_cfg.stop_ch;
            8: return $urandom_range(0, 1) ? CH_CR : CH_LF;
            9: begin
                r = $urandom_range(0, 32);
                return (r == 32) ? CH_DEL : r[7:0];
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_special(logic [7:0] dflt);
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3: return dflt;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic rand_err();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // one edited line with random content, the odd erase and kill, then a newline
    task automatic queue_line(inout int count);
        int len;
        int r;
        int pend;
        logic [7:0] ch;
        len = $urandom_range(0, 20);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 19);
            pend = ($urandom_range(0, 15) == 0) ? $urandom_range(230, 256)
                                                : int'($urandom_range(0, 8)) - 4;
            if (r < 2)
                ch = active_cfg.erase_ch;
            else if (r == 2)
                ch = active_cfg.kill_ch;
            else if (r == 3)
                ch = rand_char();
            else
                ch = 8'($urandom_range(32, 126));
            queue_char(ch, rand_err(), pend, (count % 30 == 10));
            count++;
        end
        queue_char($urandom_range(0, 1) ? CH_CR : CH_LF, rand_err(), rand_pend());
        count++;
    endtask

    initial begin
        t_line_cfg c;
        logic [1:0] mode;
        logic [7:0] flags;
        int count;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cbreak with every option on: flow control, visual echo, crlf echo, full
        apply_config(make_cfg(MODE_CBREAK, 8'hFF, START_DEF, STOP_DEF, KILL_DEF,
                              ERASE_DEF, FULL_DEF));
        queue_char(STOP_DEF, 1'b0, 0);
        queue_char(8'h41, 1'b1, -256);
        queue_char(8'h01, 1'b0, 5);
        queue_char(CH_DEL, 1'b1, 255);
        queue_char(CH_CR, 1'b0, 0);
        queue_char(8'h7A, 1'b0, 256);
        queue_char(START_DEF, 1'b0, 0);
        queue_char(STOP_DEF, 1'b0, 0);
        wait_idle();

        // raw keeps the hold state and drops only when the reader is full
        apply_config(make_cfg(MODE_RAW, 8'hFF, START_DEF, STOP_DEF, KILL_DEF,
                              ERASE_DEF, FULL_DEF));
        queue_char(START_DEF, 1'b1, -256);
        queue_char(8'hFF, 1'b0, 255);
        queue_char(8'h00, 1'b1, 256);
        wait_idle();

        // cooked via the spare mode code: erase of control and plain chars, empty erase,
        // kill, line full, cr mapped to lf releasing the line
        apply_config(make_cfg(MODE_COOKED_ALT, 8'hFF, START_DEF, STOP_DEF, KILL_DEF,
                              ERASE_DEF, FULL_DEF));
        queue_char(8'h61, 1'b0, 0);
        queue_char(8'h03, 1'b1, 0);
        queue_char(ERASE_DEF, 1'b0, 0);
        queue_char(ERASE_DEF, 1'b0, 0);
        queue_char(ERASE_DEF, 1'b0, 0);
        queue_char(8'h62, 1'b0, -1);
        queue_char(8'hFF, 1'b1, 3);
        queue_char(KILL_DEF, 1'b0, 0);
        queue_char(8'h63, 1'b0, 255);
        queue_char(8'h64, 1'b0, 254);
        queue_char(CH_CR, 1'b1, 0);
        wait_idle();

        // kill and erase on the same char: kill wins
        apply_config(make_cfg(MODE_COOKED, 8'((1 << OPT_KILL) | (1 << OPT_ERASE)),
                              START_DEF, STOP_DEF, 8'h23, 8'h23, FULL_DEF));
        queue_char(8'h71, 1'b0, 0);
        queue_char(8'h23, 1'b0, 0);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin mode = MODE_COOKED;     flags = 8'hFF; end
                1: begin mode = MODE_CBREAK;     flags = 8'($urandom_range(0, 255)); end
                2: begin mode = MODE_RAW;        flags = 8'($urandom_range(0, 255)); end
                3: begin mode = MODE_COOKED;     flags = 8'($urandom_range(0, 255)); end
                4: begin mode = MODE_COOKED_ALT; flags = 8'($urandom_range(0, 255)); end
                5: begin mode = MODE_COOKED;     flags = 8'h00; end
                default: begin mode = MODE_CBREAK; flags = 8'hFF; end
            endcase
            c = make_cfg(mode, flags, pick_special(START_DEF), pick_special(STOP_DEF),
                         pick_special(KILL_DEF), pick_special(ERASE_DEF),
                         pick_special(FULL_DEF));
            apply_config(c);
            count = 0;
            while (count < PHASE_ITEMS) begin
                if (mode != MODE_RAW && mode != MODE_CBREAK && $urandom_range(0, 4) != 0) begin
                    queue_line(count);
                end else begin
                    queue_char(rand_char(), rand_err(), rand_pend(),
                               ($urandom_range(0, 29) == 0) || (count == 4));
                    count++;
                end
            end
            wait_idle();
        end

        // one line longer than the buffer: fills to the limit, then releases it whole
        apply_config(make_cfg(MODE_COOKED,
                              8'((1 << OPT_ECHO) | (1 << OPT_ECHO_CRLF) | (1 << OPT_VISUAL)),
                              START_DEF, STOP_DEF, KILL_DEF, ERASE_DEF, FULL_DEF));
        for (int i = 0; i < LONG_LINE_CHARS; i++)
            queue_char(8'($urandom_range(32, 126)), rand_err(), 0, (i == 100));
        queue_char(CH_LF, 1'b0, 0);
        wait_idle();

        if (mismatches == 0) begin
            $display("[tty_input_line_discipline_unit] OK");
        end else begin
            $display("[tty_input_line_discipline_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: tty_input_line_discipline_unit.f
rtl/core/ttyild_pkg.sv
rtl/core/ttyild_ram.sv
rtl/core/tty_input_line_discipline_unit.sv
verif/tty_input_line_discipline_unit_tb.sv
